FILE: rtl/core/mtcr_pkg.sv
// Shared types and constants for the mesh/torus/crossbar route compute block.
// No dependencies; every other file in rtl/core refers to this package.
package mtcr_pkg;

  localparam int unsigned NODE_W     = 8;   // current_switch, dest_node
  localparam int unsigned DIM_W      = 5;   // nodes_per_router, switches_x/y
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned PORT_W     = 9;
  localparam int unsigned SW_CNT_W   = 2 * DIM_W;        // switch count x*y
  localparam int unsigned SF_W       = SW_CNT_W + DIM_W; // switch count * nodes
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Divider pipeline: quotient bits resolved per stage
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES         = NODE_W / DIV_BITS_PER_STAGE;

  typedef enum logic [MODE_W-1:0] {
    MODE_MESH     = 2'd0,
    MODE_TORUS    = 2'd1,
    MODE_CROSSBAR = 2'd2
  } topo_mode_t;

  typedef enum logic [1:0] {
    REG_TOPOLOGY_MODE    = 2'd0,
    REG_NODES_PER_ROUTER = 2'd1,
    REG_SWITCHES_X       = 2'd2,
    REG_SWITCHES_Y       = 2'd3
  } reg_idx_t;

  // Network port offsets above the local ports
  localparam logic [1:0] PORT_WEST  = 2'd0;
  localparam logic [1:0] PORT_NORTH = 2'd1;
  localparam logic [1:0] PORT_EAST  = 2'd2;
  localparam logic [1:0] PORT_SOUTH = 2'd3;

  localparam logic [MODE_W-1:0] RST_TOPOLOGY_MODE    = 2'd0;
  localparam logic [DIM_W-1:0]  RST_NODES_PER_ROUTER = 5'd1;
  localparam logic [DIM_W-1:0]  RST_SWITCHES_X       = 5'd1;
  localparam logic [DIM_W-1:0]  RST_SWITCHES_Y       = 5'd1;

  typedef struct packed {
    logic [MODE_W-1:0] topology_mode;
    logic [DIM_W-1:0]  nodes_per_router;
    logic [DIM_W-1:0]  switches_x;
    logic [DIM_W-1:0]  switches_y;
  } cfg_t;

  typedef struct packed {
    logic [NODE_W-1:0] current_switch;
    logic [NODE_W-1:0] dest_node;
  } req_t;

  typedef struct packed {
    logic [PORT_W-1:0] out_port;
    logic              out_vc;
    logic              bad_request;
  } rsp_t;

endpackage

FILE: rtl/core/mtcr_stream_ifs.sv
// Valid/ready channel interfaces for route requests and route results.
// Depends on mtcr_pkg for the payload structs.
interface mtcr_req_if;
  logic            valid;
  logic            ready;
  mtcr_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mtcr_rsp_if;
  logic            valid;
  logic            ready;
  mtcr_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/mtcr_cfg_regs.sv
// APB-style configuration registers: topology mode, nodes per router, X and Y size.
// Depends on mtcr_pkg for register indexes, reset values and cfg_t.
module mtcr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mtcr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mtcr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mtcr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mtcr_pkg::cfg_t                      cfg
);

  logic [mtcr_pkg::MODE_W-1:0] mode_r;
  logic [mtcr_pkg::DIM_W-1:0]  npr_r;
  logic [mtcr_pkg::DIM_W-1:0]  sx_r;
  logic [mtcr_pkg::DIM_W-1:0]  sy_r;
  logic                        wr_en;
  mtcr_pkg::reg_idx_t          idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = mtcr_pkg::reg_idx_t'(paddr[mtcr_pkg::APB_ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mtcr_pkg::RST_TOPOLOGY_MODE;
      npr_r  <= mtcr_pkg::RST_NODES_PER_ROUTER;
      sx_r   <= mtcr_pkg::RST_SWITCHES_X;
      sy_r   <= mtcr_pkg::RST_SWITCHES_Y;
    end else if (wr_en) begin
      unique case (idx)
        mtcr_pkg::REG_TOPOLOGY_MODE:    mode_r <= pwdata[mtcr_pkg::MODE_W-1:0];
        mtcr_pkg::REG_NODES_PER_ROUTER: npr_r  <= pwdata[mtcr_pkg::DIM_W-1:0];
        mtcr_pkg::REG_SWITCHES_X:       sx_r   <= pwdata[mtcr_pkg::DIM_W-1:0];
        mtcr_pkg::REG_SWITCHES_Y:       sy_r   <= pwdata[mtcr_pkg::DIM_W-1:0];
        default:                        mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mtcr_pkg::REG_TOPOLOGY_MODE:    prdata = mtcr_pkg::APB_DATA_W'(mode_r);
      mtcr_pkg::REG_NODES_PER_ROUTER: prdata = mtcr_pkg::APB_DATA_W'(npr_r);
      mtcr_pkg::REG_SWITCHES_X:       prdata = mtcr_pkg::APB_DATA_W'(sx_r);
      mtcr_pkg::REG_SWITCHES_Y:       prdata = mtcr_pkg::APB_DATA_W'(sy_r);
      default:                        prdata = '0;
    endcase
  end

  assign cfg.topology_mode    = mode_r;
  assign cfg.nodes_per_router = npr_r;
  assign cfg.switches_x       = sx_r;
  assign cfg.switches_y       = sy_r;

endmodule

FILE: rtl/core/mtcr_div_pipe.sv
// Pipelined restoring divider: NODE_W-bit dividends over a shared divisor,
// DIV_BITS_PER_STAGE quotient bits per stage, sideband carried alongside.
// Depends on mtcr_pkg for widths and stage count.
module mtcr_div_pipe #(
  parameter int unsigned DEN_W  = 10,
  parameter int unsigned LANES  = 1,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                               clk,
  input  logic [mtcr_pkg::DIV_STAGES-1:0]                    en,
  input  logic [LANES-1:0][mtcr_pkg::NODE_W-1:0]             num_i,
  input  logic [DEN_W-1:0]                                   den_i,
  input  logic [SIDE_W-1:0]                                  side_i,
  output logic [LANES-1:0][mtcr_pkg::NODE_W-1:0]             quot_o,
  output logic [LANES-1:0][mtcr_pkg::NODE_W-1:0]             rem_o,
  output logic [SIDE_W-1:0]                                  side_o
);

  localparam int unsigned NW    = mtcr_pkg::NODE_W;
  localparam int unsigned STG   = mtcr_pkg::DIV_STAGES;
  localparam int unsigned BPS   = mtcr_pkg::DIV_BITS_PER_STAGE;
  localparam int unsigned CMP_W = (DEN_W > NW + 1) ? DEN_W : NW + 1;

  logic [LANES-1:0][NW-1:0] nq_r    [STG];
  logic [LANES-1:0][NW-1:0] rem_r   [STG];
  logic [SIDE_W-1:0]        side_r  [STG];
  logic [DEN_W-1:0]         den_r   [STG-1];

  logic [LANES-1:0][NW-1:0] nq_in   [STG];
  logic [LANES-1:0][NW-1:0] rem_in  [STG];
  logic [DEN_W-1:0]         den_in  [STG];
  logic [SIDE_W-1:0]        side_in [STG];
  logic [LANES-1:0][NW-1:0] nq_nxt  [STG];
  logic [LANES-1:0][NW-1:0] rem_nxt [STG];

  for (genvar k = 0; k < STG; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign nq_in[k]   = num_i;
      assign rem_in[k]  = '0;
      assign den_in[k]  = den_i;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign nq_in[k]   = nq_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign den_in[k]  = den_r[k-1];
      assign side_in[k] = side_r[k-1];
    end

    // nq shifts dividend bits out at the top and quotient bits in at the bottom
    always_comb begin
      logic [NW-1:0]    nq;
      logic [NW-1:0]    rem;
      logic [CMP_W-1:0] trial;
      nq_nxt[k]  = '0;
      rem_nxt[k] = '0;
      for (int l = 0; l < LANES; l++) begin
        nq  = nq_in[k][l];
        rem = rem_in[k][l];
        for (int j = 0; j < BPS; j++) begin
          trial = CMP_W'({rem, nq[NW-1]});
          nq    = {nq[NW-2:0], 1'b0};
          if (trial >= CMP_W'(den_in[k])) begin
            trial = trial - CMP_W'(den_in[k]);
            nq[0] = 1'b1;
          end
          rem = trial[NW-1:0];
        end
        nq_nxt[k][l]  = nq;
        rem_nxt[k][l] = rem;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        nq_r[k]   <= nq_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        side_r[k] <= side_in[k];
      end
    end

    if (k < STG - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en[k]) begin
          den_r[k] <= den_in[k];
        end
      end
    end
  end

  assign quot_o = nq_r[STG-1];
  assign rem_o  = rem_r[STG-1];
  assign side_o = side_r[STG-1];

endmodule

FILE: rtl/core/mtcr_route_sel.sv
// Final stage: picks local, crossbar, mesh or torus output port and VC,
// and registers the result. Depends on mtcr_pkg for cfg_t, rsp_t and port codes.
module mtcr_route_sel (
  input  logic                          clk,
  input  logic                          en,
  input  mtcr_pkg::cfg_t                cfg,
  input  logic                          bad,
  input  logic [mtcr_pkg::NODE_W-1:0]   cur,
  input  logic [mtcr_pkg::NODE_W-1:0]   dsw,
  input  logic [mtcr_pkg::NODE_W-1:0]   local_idx,
  input  logic [mtcr_pkg::NODE_W-1:0]   dx,
  input  logic [mtcr_pkg::NODE_W-1:0]   dy,
  input  logic [mtcr_pkg::NODE_W-1:0]   cx,
  input  logic [mtcr_pkg::NODE_W-1:0]   cy,
  output mtcr_pkg::rsp_t                rsp
);

  localparam int unsigned NW = mtcr_pkg::NODE_W;
  localparam int unsigned PW = mtcr_pkg::PORT_W;

  mtcr_pkg::rsp_t        rsp_r;
  mtcr_pkg::rsp_t        rsp_nxt;
  logic signed [NW:0]    xoff;
  logic signed [NW:0]    yoff;
  logic [PW-1:0]         f_ext;

  // Shorter way round; a tie goes west or north
  function automatic logic east_or_south(input logic signed [NW:0] off,
                                         input logic [mtcr_pkg::DIM_W-1:0] n);
    logic signed [NW+1:0] dbl;
    logic signed [NW+1:0] nn;
    dbl = {off, 1'b0};
    nn  = $signed({{(NW + 2 - mtcr_pkg::DIM_W){1'b0}}, n});
    return (off > 0 && dbl < nn) || (off < 0 && -dbl > nn);
  endfunction

  assign xoff  = $signed({1'b0, dx}) - $signed({1'b0, cx});
  assign yoff  = $signed({1'b0, dy}) - $signed({1'b0, cy});
  assign f_ext = PW'(cfg.nodes_per_router);

  always_comb begin
    rsp_nxt.out_port    = '0;
    rsp_nxt.out_vc      = 1'b0;
    rsp_nxt.bad_request = bad;
    priority if (bad) begin
      rsp_nxt.out_port = '0;
    end else if (dsw == cur) begin
      rsp_nxt.out_port = PW'(local_idx);
    end else if (cfg.topology_mode == mtcr_pkg::MODE_CROSSBAR) begin
      rsp_nxt.out_port = f_ext + PW'(dsw);
    end else if (cfg.topology_mode == mtcr_pkg::MODE_TORUS) begin
      if (xoff != 0) begin
        rsp_nxt.out_port = east_or_south(xoff, cfg.switches_x)
                         ? f_ext + PW'(mtcr_pkg::PORT_EAST)
                         : f_ext + PW'(mtcr_pkg::PORT_WEST);
        rsp_nxt.out_vc   = dx > cx;
      end else begin
        rsp_nxt.out_port = east_or_south(yoff, cfg.switches_y)
                         ? f_ext + PW'(mtcr_pkg::PORT_SOUTH)
                         : f_ext + PW'(mtcr_pkg::PORT_NORTH);
        rsp_nxt.out_vc   = dy > cy;
      end
    end else begin
      priority if (xoff < 0)      rsp_nxt.out_port = f_ext + PW'(mtcr_pkg::PORT_WEST);
      else if (xoff > 0)          rsp_nxt.out_port = f_ext + PW'(mtcr_pkg::PORT_EAST);
      else if (yoff < 0)          rsp_nxt.out_port = f_ext + PW'(mtcr_pkg::PORT_NORTH);
      else                        rsp_nxt.out_port = f_ext + PW'(mtcr_pkg::PORT_SOUTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign rsp = rsp_r;

endmodule

FILE: rtl/core/mesh_torus_crossbar_route_compute.sv
// Top level of the route compute block: config registers, check stages,
// two divider pipelines and the port select stage. Depends on mtcr_pkg,
// mtcr_stream_ifs, mtcr_cfg_regs, mtcr_div_pipe and mtcr_route_sel.
//
//  channel  direction  handshake            payload
//  in_s     sink       valid/ready          current_switch, dest_node
//  out_s    source     valid/ready          out_port, out_vc, bad_request
//  apb      slave      psel/penable/pready  4 registers at byte address 4*i
//
// From accept to result valid a transaction passes capture, range check, four
// stages of dest_node / switch count, four stages of (switch, current) / switches_x,
// and the port select register. One transaction per cycle while out_s.ready is high.
// Reset is synchronous and clears the stage valid bits and config registers.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up and a stall drops or repeats nothing.
module mesh_torus_crossbar_route_compute #(
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_DIM   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mtcr_req_if.sink                            in_s,
  mtcr_rsp_if.source                          out_s,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mtcr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mtcr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mtcr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned NW     = mtcr_pkg::NODE_W;
  localparam int unsigned DS     = mtcr_pkg::DIV_STAGES;
  localparam int unsigned ST_CAP = 0;
  localparam int unsigned ST_CHK = 1;
  localparam int unsigned ST_DA  = 2;
  localparam int unsigned ST_DB  = ST_DA + DS;
  localparam int unsigned ST_OUT = ST_DB + DS;
  localparam int unsigned NST    = ST_OUT + 1;
  localparam int unsigned SIDE_A = NW + 1;
  localparam int unsigned SIDE_B = 3 * NW + 1;

  mtcr_pkg::cfg_t                     cfg;
  logic [NST-1:0]                     valid_r;
  logic [NST-1:0]                     valid_nxt;
  logic [NST-1:0]                     en;

  logic [NW-1:0]                      cap_cur_r;
  logic [NW-1:0]                      cap_dst_r;
  logic [mtcr_pkg::SW_CNT_W-1:0]      cap_s_r;
  logic [mtcr_pkg::SW_CNT_W-1:0]      s_cnt;

  logic [NW-1:0]                      chk_cur_r;
  logic [NW-1:0]                      chk_dst_r;
  logic [mtcr_pkg::SW_CNT_W-1:0]      chk_s_r;
  logic                               chk_bad_r;
  logic [mtcr_pkg::SF_W-1:0]          sf;
  logic                               cfg_bad;
  logic                               chk_bad;

  logic [0:0][NW-1:0]                 a_quot;
  logic [0:0][NW-1:0]                 a_rem;
  logic [SIDE_A-1:0]                  a_side;
  logic [NW-1:0]                      a_cur;
  logic                               a_bad;

  logic [1:0][NW-1:0]                 b_quot;
  logic [1:0][NW-1:0]                 b_rem;
  logic [SIDE_B-1:0]                  b_side;
  logic [NW-1:0]                      b_cur;
  logic [NW-1:0]                      b_dsw;
  logic [NW-1:0]                      b_local;
  logic                               b_bad;

  mtcr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage enables: advance when empty or when the next stage advances
  always_comb begin
    en[NST-1] = !valid_r[NST-1] || out_s.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  assign valid_nxt = {valid_r[NST-2:0], in_s.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) valid_r[i] <= valid_nxt[i];
      end
    end
  end

  assign in_s.ready  = en[ST_CAP];
  assign out_s.valid = valid_r[ST_OUT];

  // Capture: request and switch count
  assign s_cnt = mtcr_pkg::SW_CNT_W'(cfg.switches_x) * mtcr_pkg::SW_CNT_W'(cfg.switches_y);

  always_ff @(posedge clk) begin
    if (en[ST_CAP]) begin
      cap_cur_r <= in_s.data.current_switch;
      cap_dst_r <= in_s.data.dest_node;
      cap_s_r   <= s_cnt;
    end
  end

  // Range check against the configured network
  assign sf = mtcr_pkg::SF_W'(cap_s_r) * mtcr_pkg::SF_W'(cfg.nodes_per_router);

  assign cfg_bad = !(cfg.topology_mode == mtcr_pkg::MODE_MESH ||
                     cfg.topology_mode == mtcr_pkg::MODE_TORUS ||
                     cfg.topology_mode == mtcr_pkg::MODE_CROSSBAR) ||
                   cfg.nodes_per_router == '0 ||
                   cfg.switches_x == '0 || cfg.switches_y == '0 ||
                   32'(cfg.switches_x) > MAX_DIM || 32'(cfg.switches_y) > MAX_DIM;

  assign chk_bad = cfg_bad || 32'(sf) > MAX_NODES ||
                   mtcr_pkg::SW_CNT_W'(cap_cur_r) >= cap_s_r ||
                   mtcr_pkg::SF_W'(cap_dst_r) >= sf;

  always_ff @(posedge clk) begin
    if (en[ST_CHK]) begin
      chk_cur_r <= cap_cur_r;
      chk_dst_r <= cap_dst_r;
      chk_s_r   <= cap_s_r;
      chk_bad_r <= chk_bad;
    end
  end

  // dest_node / switch count: quotient is the local port, remainder the switch
  mtcr_div_pipe #(
    .DEN_W  (mtcr_pkg::SW_CNT_W),
    .LANES  (1),
    .SIDE_W (SIDE_A)
  ) u_div_node (
    .clk    (clk),
    .en     (en[ST_DA +: DS]),
    .num_i  (chk_dst_r),
    .den_i  (chk_s_r),
    .side_i ({chk_cur_r, chk_bad_r}),
    .quot_o (a_quot),
    .rem_o  (a_rem),
    .side_o (a_side)
  );

  assign {a_cur, a_bad} = a_side;

  // Destination and current switch split into x (remainder) and y (quotient)
  mtcr_div_pipe #(
    .DEN_W  (mtcr_pkg::DIM_W),
    .LANES  (2),
    .SIDE_W (SIDE_B)
  ) u_div_xy (
    .clk    (clk),
    .en     (en[ST_DB +: DS]),
    .num_i  ({a_cur, a_rem[0]}),
    .den_i  (cfg.switches_x),
    .side_i ({a_cur, a_rem[0], a_quot[0], a_bad}),
    .quot_o (b_quot),
    .rem_o  (b_rem),
    .side_o (b_side)
  );

  assign {b_cur, b_dsw, b_local, b_bad} = b_side;

  mtcr_route_sel u_sel (
    .clk       (clk),
    .en        (en[ST_OUT]),
    .cfg       (cfg),
    .bad       (b_bad),
    .cur       (b_cur),
    .dsw       (b_dsw),
    .local_idx (b_local),
    .dx        (b_rem[0]),
    .dy        (b_quot[0]),
    .cx        (b_rem[1]),
    .cy        (b_quot[1]),
    .rsp       (out_s.data)
  );

  // Input may only be refused when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_s.ready |-> &valid_r)
    else $error("input refused while the pipeline has an empty stage");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.data.bad_request |->
      out_s.data.out_port == '0 && !out_s.data.out_vc)
    else $error("flagged request carries a nonzero port or VC");

  a_vc_torus: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.data.out_vc |-> cfg.topology_mode == mtcr_pkg::MODE_TORUS)
    else $error("VC 1 chosen outside torus mode");

endmodule
